// ----- hw/rtl/llst_pkg.sv -----
// package for the least loaded server table
// shared constants, payload structs and queue entry type; no dependencies
`timescale 1ns / 1ps

package llst_pkg;

  localparam int unsigned MaxServices = 16;
  localparam int unsigned MaxServers  = 8;
  localparam int unsigned SvcW        = $clog2(MaxServices);
  localparam int unsigned SrvW        = $clog2(MaxServers);
  localparam int unsigned CntW        = $clog2(MaxServers + 1);
  localparam int unsigned EntW        = SvcW + SrvW;
  localparam int unsigned NumEntries  = MaxServices * MaxServers;

  typedef enum logic [1:0] {
    ActInsert  = 2'd0,
    ActRemove  = 2'd1,
    ActRequest = 2'd2,
    ActConsult = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StDup      = 2'd1,
    StNotFound = 2'd2,
    StFull     = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] service_key;
    logic [31:0] server_ip;
    logic [15:0] server_port;
    logic [31:0] initial_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] chosen_ip;
    logic [15:0] chosen_port;
    logic [31:0] load_count;
    logic        last_result;
  } out_item_t;

  // classified beat handed from front to back
  typedef struct packed {
    logic [1:0]      action;
    logic            found;
    logic            free_ok;
    logic [SvcW-1:0] slot;
    logic [CntW-1:0] count;
    logic [31:0]     server_ip;
    logic [15:0]     server_port;
    logic [31:0]     initial_count;
  } job_t;

  // table update from back to front
  typedef struct packed {
    logic            valid;
    logic            create;
    logic            remove;
    logic            add;
    logic [SvcW-1:0] slot;
    logic [63:0]     key;
  } tbl_upd_t;

endpackage

// ----- hw/rtl/llst_front.sv -----
// front part: service table lookup and slot allocation
// depends on llst_pkg
`timescale 1ns / 1ps

module llst_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  llst_pkg::in_item_t  in_data_i,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output llst_pkg::job_t      job_o,
  input  llst_pkg::tbl_upd_t  upd_i,
  input  logic                back_idle_i
);

  logic [llst_pkg::MaxServices-1:0] used_q;
  logic [63:0]                      id_q [llst_pkg::MaxServices];
  logic [llst_pkg::CntW-1:0]        cnt_q [llst_pkg::MaxServices];
  logic                             busy_q;

  logic                      hit, free_ok;
  logic [llst_pkg::SvcW-1:0] hit_idx, free_idx;

  // one item in flight: table must settle before next lookup
  assign in_ready_o  = !busy_q && back_idle_i && job_ready_i;
  assign job_valid_o = in_valid_i && in_ready_o;

  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_ok  = 1'b0;
    free_idx = '0;
    for (int s = llst_pkg::MaxServices - 1; s >= 0; s--) begin
      if (used_q[s] && id_q[s] == in_data_i.service_key) begin
        hit     = 1'b1;
        hit_idx = llst_pkg::SvcW'(s);
      end
      if (!used_q[s]) begin
        free_ok  = 1'b1;
        free_idx = llst_pkg::SvcW'(s);
      end
    end
  end

  always_comb begin
    job_o               = '0;
    job_o.action        = in_data_i.action;
    job_o.found         = hit;
    job_o.free_ok       = free_ok;
    job_o.slot          = hit ? hit_idx : free_idx;
    job_o.count         = hit ? cnt_q[hit_idx] : '0;
    job_o.server_ip     = in_data_i.server_ip;
    job_o.server_port   = in_data_i.server_port;
    job_o.initial_count = in_data_i.initial_count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      busy_q <= 1'b0;
    end else begin
      if (job_valid_o) begin
        busy_q <= 1'b1;
      end else if (upd_i.valid) begin
        busy_q <= 1'b0;
      end
      if (upd_i.valid && upd_i.create) begin
        used_q[upd_i.slot] <= 1'b1;
      end
      if (upd_i.valid && upd_i.remove) begin
        used_q[upd_i.slot] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.valid && upd_i.create) begin
      id_q[upd_i.slot]  <= upd_i.key;
      cnt_q[upd_i.slot] <= llst_pkg::CntW'(1);
    end else if (upd_i.valid && upd_i.add) begin
      cnt_q[upd_i.slot] <= cnt_q[upd_i.slot] + llst_pkg::CntW'(1);
    end
  end

endmodule

// ----- hw/rtl/llst_queue.sv -----
// two entry queue between front and back
// depends on llst_pkg
`timescale 1ns / 1ps

module llst_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  llst_pkg::job_t  wr_data_i,
  output logic            rd_valid_o,
  input  logic            rd_ready_i,
  output llst_pkg::job_t  rd_data_o
);

  llst_pkg::job_t mem_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     fill_q;
  logic           wr_en, rd_en;

  assign wr_ready_o = fill_q != 2'd2;
  assign rd_valid_o = fill_q != 2'd0;
  assign rd_data_o  = mem_q[rptr_q];
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= '0;
    end else begin
      if (wr_en) wptr_q <= !wptr_q;
      if (rd_en) rptr_q <= !rptr_q;
      fill_q <= fill_q + 2'(wr_en) - 2'(rd_en);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wptr_q] <= wr_data_i;
  end

endmodule

// ----- hw/rtl/llst_back.sv -----
// back part: server entry memory, duplicate scan, least count search, listing
// depends on llst_pkg
`timescale 1ns / 1ps

module llst_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  output logic                job_ready_o,
  input  llst_pkg::job_t      job_i,
  input  logic [63:0]         key_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output llst_pkg::out_item_t out_data_o,
  output llst_pkg::tbl_upd_t  upd_o,
  output logic                idle_o
);

  typedef enum logic [5:0] {
    SIdle = 6'b000001,
    SRead = 6'b000010,
    SScan = 6'b000100,
    SDone = 6'b001000,
    SEmit = 6'b010000,
    SWait = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [31:0] addr_mem [llst_pkg::NumEntries];
  logic [15:0] port_mem [llst_pkg::NumEntries];
  logic [31:0] load_mem [llst_pkg::NumEntries];

  llst_pkg::job_t      job_q;
  logic [63:0]         key_q;
  logic [llst_pkg::CntW-1:0] idx_q;
  logic [llst_pkg::SrvW-1:0] best_q;
  logic [31:0]         best_load_q;
  logic                dup_q;
  logic [31:0]         rd_addr_q, rd_load_q;
  logic [15:0]         rd_port_q;
  logic                out_valid_q;
  llst_pkg::out_item_t out_q;

  logic [llst_pkg::EntW-1:0] rd_ent, wr_ent;
  logic        wr_en;
  logic [31:0] wr_addr, wr_load;
  logic [15:0] wr_port;
  logic        emit;
  llst_pkg::out_item_t res;
  logic        last_idx;

  assign job_ready_o = state_q == SIdle;
  assign idle_o      = state_q == SIdle && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign last_idx    = idx_q + llst_pkg::CntW'(1) == job_q.count;

  // read address: scan index, then the final pick of the least count entry, held while the result waits
  always_comb begin
    rd_ent = {job_q.slot, idx_q[llst_pkg::SrvW-1:0]};
    if (state_q == SDone && job_q.action != llst_pkg::ActInsert) begin
      rd_ent = (rd_load_q < best_load_q) ?
               {job_q.slot, llst_pkg::SrvW'(job_q.count - llst_pkg::CntW'(1))} :
               {job_q.slot, best_q};
    end
    if (state_q == SWait) rd_ent = {job_q.slot, best_q};
  end

  // registered memory read
  always_ff @(posedge clk_i) begin
    rd_addr_q <= addr_mem[rd_ent];
    rd_port_q <= port_mem[rd_ent];
    rd_load_q <= load_mem[rd_ent];
    if (wr_en) begin
      addr_mem[wr_ent] <= wr_addr;
      port_mem[wr_ent] <= wr_port;
      load_mem[wr_ent] <= wr_load;
    end
  end

  always_comb begin
    state_d = state_q;
    wr_en   = 1'b0;
    wr_ent  = {job_q.slot, idx_q[llst_pkg::SrvW-1:0]};
    wr_addr = job_q.server_ip;
    wr_port = job_q.server_port;
    wr_load = job_q.initial_count;
    emit    = 1'b0;
    res     = '0;
    res.last_result = 1'b1;
    upd_o   = '0;
    upd_o.slot = job_q.slot;
    upd_o.key  = key_q;
    case (state_q)
      SIdle: begin
        if (job_valid_i) state_d = SRead;
      end
      SRead: begin
        if (!job_q.found || job_q.count == '0) begin
          if (job_q.action == llst_pkg::ActRemove && job_q.found) begin
            res.status = llst_pkg::StOk;
            upd_o.remove = 1'b1;
          end else if (job_q.action == llst_pkg::ActInsert) begin
            if (job_q.free_ok || job_q.found) begin
              wr_en  = 1'b1;
              wr_ent = {job_q.slot, {llst_pkg::SrvW{1'b0}}};
              res.status      = llst_pkg::StOk;
              res.chosen_ip   = job_q.server_ip;
              res.chosen_port = job_q.server_port;
              res.load_count  = job_q.initial_count;
              upd_o.create    = 1'b1;
            end else begin
              res.status = llst_pkg::StFull;
            end
          end else begin
            res.status = llst_pkg::StNotFound;
          end
          emit = 1'b1;
        end else if (job_q.action == llst_pkg::ActRemove) begin
          res.status   = llst_pkg::StOk;
          upd_o.remove = 1'b1;
          emit         = 1'b1;
        end else begin
          state_d = SScan;
        end
      end
      SScan: begin
        if (job_q.action == llst_pkg::ActConsult) begin
          state_d = SEmit;
        end else if (last_idx) begin
          state_d = SDone;
        end
      end
      SDone: begin
        if (job_q.action == llst_pkg::ActInsert) begin
          if (dup_q || (job_q.found && rd_addr_q == job_q.server_ip
                        && rd_port_q == job_q.server_port)) begin
            res.status = llst_pkg::StDup;
          end else if (32'(job_q.count) >= 32'(llst_pkg::MaxServers)) begin
            res.status = llst_pkg::StFull;
          end else begin
            wr_en  = 1'b1;
            wr_ent = {job_q.slot, job_q.count[llst_pkg::SrvW-1:0]};
            res.status      = llst_pkg::StOk;
            res.chosen_ip   = job_q.server_ip;
            res.chosen_port = job_q.server_port;
            res.load_count  = job_q.initial_count;
            upd_o.add       = 1'b1;
          end
          emit = 1'b1;
        end else begin
          state_d = SWait;
        end
      end
      SWait: begin
        wr_en   = 1'b1;
        wr_ent  = {job_q.slot, best_q};
        wr_addr = rd_addr_q;
        wr_port = rd_port_q;
        wr_load = (rd_load_q == '1) ? rd_load_q : rd_load_q + 32'd1;
        res.status      = llst_pkg::StOk;
        res.chosen_ip   = rd_addr_q;
        res.chosen_port = rd_port_q;
        res.load_count  = wr_load;
        emit = 1'b1;
      end
      SEmit: begin
        if (!out_valid_q || out_ready_i) begin
          res.status      = llst_pkg::StOk;
          res.chosen_ip   = rd_addr_q;
          res.chosen_port = rd_port_q;
          res.load_count  = rd_load_q;
          res.last_result = last_idx;
          emit    = 1'b1;
          state_d = last_idx ? SIdle : SScan;
        end
      end
      default: state_d = SIdle;
    endcase
    // single result states wait for the output register
    if (emit && state_q != SEmit) begin
      if (out_valid_q && !out_ready_i) begin
        emit = 1'b0;
        wr_en = 1'b0;
        upd_o = '0;
        upd_o.slot = job_q.slot;
        upd_o.key  = key_q;
        state_d = state_q;
      end else begin
        upd_o.valid = 1'b1;
        state_d = SIdle;
      end
    end
    if (state_q == SEmit && emit && last_idx) upd_o.valid = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q <= state_d;
      if (emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (state_q == SIdle) idx_q <= '0;
      else if (state_q == SScan && job_q.action != llst_pkg::ActConsult && !last_idx)
        idx_q <= idx_q + llst_pkg::CntW'(1);
      else if (state_q == SEmit && emit && !last_idx)
        idx_q <= idx_q + llst_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && job_valid_i) begin
      job_q <= job_i;
      key_q <= key_i;
      dup_q <= 1'b0;
      best_q <= '0;
      best_load_q <= '1;
    end
    // scan sees the entry read in the cycle after its index
    if (state_q == SScan && job_q.action != llst_pkg::ActConsult && idx_q != '0) begin
      if (rd_addr_q == job_q.server_ip && rd_port_q == job_q.server_port) dup_q <= 1'b1;
      if (idx_q == llst_pkg::CntW'(1) || rd_load_q < best_load_q) begin
        best_load_q <= rd_load_q;
        best_q      <= llst_pkg::SrvW'(idx_q - llst_pkg::CntW'(1));
      end
    end
    if (state_q == SDone) begin
      if (rd_load_q < best_load_q || job_q.count == llst_pkg::CntW'(1)) begin
        if (job_q.count == llst_pkg::CntW'(1) || rd_load_q < best_load_q)
          best_q <= llst_pkg::SrvW'(job_q.count - llst_pkg::CntW'(1));
      end
    end
    if (emit) out_q <= res;
  end

  property p_out_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_q);
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result changed while stalled");

  a_one_hot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one hot");

  a_idle_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i && job_ready_o |=> state_q == SRead) else $error("lost job");

endmodule

// ----- hw/rtl/least_loaded_server_table.sv -----
// least loaded server table: 16 services of up to 8 servers each
// a request or insert on a service with servers scans its entries, one server
// entry read a cycle; a consult gives one result beat per server entry; one
// item at a time, the next input beat is taken once the back part is idle and
// its last result beat has left
// reset clears the service valid bits at once; no clearing pass
`timescale 1ns / 1ps

module least_loaded_server_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  llst_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output llst_pkg::out_item_t out_data_o
);

  logic               fj_valid, fj_ready, bj_valid, bj_ready, back_idle;
  llst_pkg::job_t     fj, bj;
  llst_pkg::tbl_upd_t upd;
  logic [63:0]        key_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) key_q <= in_data_i.service_key;
  end

  llst_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .job_valid_o(fj_valid), .job_ready_i(fj_ready), .job_o(fj),
    .upd_i(upd), .back_idle_i(back_idle)
  );

  llst_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(fj_valid), .wr_ready_o(fj_ready), .wr_data_i(fj),
    .rd_valid_o(bj_valid), .rd_ready_i(bj_ready), .rd_data_o(bj)
  );

  llst_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(bj_valid), .job_ready_o(bj_ready), .job_i(bj), .key_i(key_q),
    .out_valid_o, .out_ready_i, .out_data_o,
    .upd_o(upd), .idle_o(back_idle)
  );

endmodule
